// ----- sv/scfir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfir_pkg
// Shared types, codes and sizing helpers for the sliding correlation FIR.
// ----------------------------------------------------------------------------
package scfir_pkg;

    localparam int DEF_MAX_TAPS = 16;
    localparam int VAL_W        = 16;
    localparam int PROD_W       = 32;
    localparam int SUM_W        = 40;
    localparam int RIDX_W       = 16;
    localparam int TAPCNT_W     = 5;
    localparam int TIDX_W       = 4;
    localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 5'd16;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic sample_move;
        logic coef_move;
    } t_cell_ctrl;

    typedef struct packed {
        t_cell_ctrl tap;
        logic       shift_new;
    } t_chain_ctrl;

    typedef struct packed {
        logic clear;
        logic en;
    } t_mac_ctrl;

    // Width of an index into a bank of n entries.
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Width of a count that can hold n itself.
    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

// ----- sv/scfir_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfir_cell
// One tap of the chain: a coefficient and a window sample, each passed on to
// a neighbor when the chain moves.
// ----------------------------------------------------------------------------
module scfir_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  scfir_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                  i_coef_load,
    input  logic signed [scfir_pkg::VAL_W-1:0]    i_coef_data,
    input  logic signed [scfir_pkg::VAL_W-1:0]    i_sample,
    input  logic signed [scfir_pkg::VAL_W-1:0]    i_coef,
    output logic signed [scfir_pkg::VAL_W-1:0]    o_sample,
    output logic signed [scfir_pkg::VAL_W-1:0]    o_coef
);
    import scfir_pkg::*;

    logic signed [VAL_W-1:0] r_sample;
    logic signed [VAL_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_coef   <= '0;
        end else begin
            if (i_ctrl.sample_move) begin
                r_sample <= i_sample;
            end
            if (i_coef_load) begin
                r_coef <= i_coef_data;
            end else if (i_ctrl.coef_move) begin
                r_coef <= i_coef;
            end
        end
    end

    assign o_sample = r_sample;
    assign o_coef   = r_coef;

endmodule

// ----- sv/scfir_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfir_mac
// Registered 16x16 multiplier followed by a 40-bit accumulator.
// ----------------------------------------------------------------------------
module scfir_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  scfir_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [scfir_pkg::VAL_W-1:0]    i_coef,
    input  logic signed [scfir_pkg::VAL_W-1:0]    i_sample,
    output logic signed [scfir_pkg::SUM_W-1:0]    o_sum
);
    import scfir_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [SUM_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    assign o_sum = r_acc;

endmodule

// ----- sv/scfir_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfir_ctrl
// Sequencer: accepts words, tracks the fill count and result index, and
// walks the chain once around for each sample that yields a result.
// ----------------------------------------------------------------------------
module scfir_ctrl #(
    parameter int MAX_TAPS = scfir_pkg::DEF_MAX_TAPS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_valid,
    input  logic                                        i_mode,
    input  logic                                        i_first,
    input  logic [scfir_pkg::TAPCNT_W-1:0]              i_tap_count,
    input  logic                                        i_out_free,
    output logic                                        o_s_ready,
    output scfir_pkg::t_chain_ctrl                      o_chain,
    output scfir_pkg::t_mac_ctrl                        o_mac,
    output logic                                        o_out_load,
    output logic [scfir_pkg::idx_w(MAX_TAPS)-1:0]       o_tap_sel,
    output logic [scfir_pkg::RIDX_W-1:0]                o_result_index
);
    import scfir_pkg::*;

    localparam int IW = idx_w(MAX_TAPS);
    localparam int FW = cnt_w(MAX_TAPS);
    localparam logic [IW-1:0] LAST_STEP = IW'(MAX_TAPS - 1);

    t_state              r_state, n_state;
    logic [IW-1:0]       r_step, n_step;
    logic [FW-1:0]       r_fill, n_fill;
    logic [RIDX_W-1:0]   r_cnt, n_cnt;
    logic [FW-1:0]       taps_eff;
    logic [FW-1:0]       fill_base;
    logic                smp_acc;

    // A tap count of zero acts as one, anything above the bank as the bank.
    always_comb begin
        if (i_tap_count == '0) begin
            taps_eff = FW'(1);
        end else if (int'(i_tap_count) > MAX_TAPS) begin
            taps_eff = FW'(MAX_TAPS);
        end else begin
            taps_eff = FW'(i_tap_count);
        end
    end

    assign o_tap_sel = IW'(taps_eff - FW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        o_s_ready  = 1'b0;
        o_chain    = '0;
        o_mac      = '0;
        o_out_load = 1'b0;
        smp_acc    = 1'b0;
        fill_base  = r_fill;

        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                smp_acc   = i_s_valid && (i_mode == MODE_SAMPLE);
                if (smp_acc) begin
                    o_chain.tap.sample_move = 1'b1;
                    o_chain.shift_new       = 1'b1;
                    o_mac.clear             = 1'b1;
                    fill_base = i_first ? '0 : r_fill;
                    if (i_first) begin
                        n_cnt = '0;
                    end
                    n_fill = (int'(fill_base) < MAX_TAPS) ? fill_base + FW'(1) : fill_base;
                    if (n_fill >= taps_eff) begin
                        n_state = S_RUN;
                        n_step  = '0;
                    end
                end
            end
            S_RUN: begin
                // A full turn of both chains puts every tap back in place.
                o_chain.tap.sample_move = 1'b1;
                o_chain.tap.coef_move   = 1'b1;
                o_mac.en = (FW'(r_step) < taps_eff);
                n_step   = r_step + IW'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_DRAIN;
                    n_step  = '0;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_cnt      = r_cnt + RIDX_W'(1);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_index = r_cnt;

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == LAST_STEP) |=> (r_state == S_DRAIN))
        else $error("chain walk did not end after one full turn");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= MAX_TAPS)
        else $error("fill count above the bank size");

    a_first_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (smp_acc && i_first) |=> (r_fill == FW'(1)))
        else $error("first sample did not restart the fill count");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_free) |=> (r_state == S_IDLE && r_cnt != $past(r_cnt)))
        else $error("result hand-off did not advance the result index");

endmodule

// ----- sv/sliding_correlation_fir.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_correlation_fir
// Valid-mode sliding dot product of a sample stream with a loaded kernel.
//
// Input words arrive on the s-side stream. tuser[0] selects the kind: zero
// loads value into coefficient tap_index, one pushes value as a sample;
// tuser[1] marks the first sample of a new signal and restarts the fill
// count and the result index. Once tap_count samples of the signal are in,
// each sample gives one result word on the m-side stream.
// The tap count must be written on the cfg channel while the block is idle;
// the block itself does not enforce this. A load, or a sample that gives no
// result, leaves the block ready for the next word. For a sample that gives a
// result, the coefficient and sample rows rotate one full turn past a single
// multiply-accumulate unit, then the pipeline drains and the sum is written
// to the output register once it is free; no words are taken meanwhile.
// While a result waits in the output register the block keeps taking words;
// a following result holds in the sequencer until the register is free.
// Reset clears coefficients, window, counts and the output valid, and sets
// the tap count to 16.
// ----------------------------------------------------------------------------
module sliding_correlation_fir #(
    parameter int MAX_TAPS = scfir_pkg::DEF_MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cfg write channel: tap_count [4:0]
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scfir_pkg::TAPCNT_W-1:0]      i_cfg_data,
    // s-side tdata: tap_index [3:0], value [19:4], zero [23:20]
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [23:0]                         i_s_tdata,
    // s-side tuser: mode [0], first_sample [1]
    input  logic [1:0]                          i_s_tuser,
    // m-side tdata: dot_sum [39:0], result_index [55:40]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [55:0]                         o_m_tdata
);
    import scfir_pkg::*;

    localparam int IW = idx_w(MAX_TAPS);

    logic [TAPCNT_W-1:0]       r_tap_count;
    logic                      in_mode;
    logic                      in_first;
    logic [TIDX_W-1:0]         in_tap_index;
    logic signed [VAL_W-1:0]   in_value;
    logic                      load_hit;
    logic                      out_free;
    t_chain_ctrl               chain;
    t_mac_ctrl                 mac;
    logic                      out_load;
    logic [IW-1:0]             tap_sel;
    logic [RIDX_W-1:0]         result_index;
    logic signed [SUM_W-1:0]   mac_sum;
    logic signed [VAL_W-1:0]   cell_sample [MAX_TAPS];
    logic signed [VAL_W-1:0]   cell_coef   [MAX_TAPS];
    logic signed [VAL_W-1:0]   head_sample;
    logic                      r_m_valid;
    logic [55:0]               r_m_data;

    assign in_mode      = i_s_tuser[0];
    assign in_first     = i_s_tuser[1];
    assign in_tap_index = i_s_tdata[TIDX_W-1:0];
    assign in_value     = i_s_tdata[TIDX_W +: VAL_W];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAPCNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tap_count <= i_cfg_data;
        end
    end

    assign load_hit = i_s_tvalid && o_s_tready && (in_mode == MODE_LOAD)
                      && (int'(in_tap_index) < MAX_TAPS);
    assign out_free = !r_m_valid || i_m_tready;

    scfir_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (i_s_tvalid),
        .i_mode         (in_mode),
        .i_first        (in_first),
        .i_tap_count    (r_tap_count),
        .i_out_free     (out_free),
        .o_s_ready      (o_s_tready),
        .o_chain        (chain),
        .o_mac          (mac),
        .o_out_load     (out_load),
        .o_tap_sel      (tap_sel),
        .o_result_index (result_index)
    );

    // Samples move toward higher cells, coefficients toward cell zero; both
    // rows close into rings while the sum is formed.
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        localparam int PREV = (k + MAX_TAPS - 1) % MAX_TAPS;
        localparam int NEXT = (k + 1) % MAX_TAPS;
        logic signed [VAL_W-1:0] smp_in;
        logic                    coef_ld;

        if (k == 0) begin : g_head
            assign smp_in = chain.shift_new ? in_value : cell_sample[PREV];
        end else begin : g_body
            assign smp_in = cell_sample[PREV];
        end

        assign coef_ld = load_hit && (int'(in_tap_index) == k);

        scfir_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (chain.tap),
            .i_coef_load (coef_ld),
            .i_coef_data (in_value),
            .i_sample    (smp_in),
            .i_coef      (cell_coef[NEXT]),
            .o_sample    (cell_sample[k]),
            .o_coef      (cell_coef[k])
        );
    end

    assign head_sample = cell_sample[tap_sel];

    scfir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac),
        .i_coef   (cell_coef[0]),
        .i_sample (head_sample),
        .o_sum    (mac_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {result_index, mac_sum};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
